### rtl/nonblocking_lru_cache_with_mshr_assert.svh
// Assertion macros used by the cache top-level RTL file.
`ifndef NONBLOCKING_LRU_CACHE_WITH_MSHR_ASSERT_SVH
`define NONBLOCKING_LRU_CACHE_WITH_MSHR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define NLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define NLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/nlc_pkg.sv
// Package: shared types and codes for the cache tag controller.
package nlc_pkg;

    localparam int unsigned FIELD_ADDR_W = 32;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_PEND_HIT    = 3'd1;
    localparam logic [2:0] ST_MISS_ALLOC  = 3'd2;
    localparam logic [2:0] ST_STALL_TABLE = 3'd3;
    localparam logic [2:0] ST_STALL_SET   = 3'd4;
    localparam logic [2:0] ST_FILL_MATCH  = 3'd5;
    localparam logic [2:0] ST_FILL_NONE   = 3'd6;

    typedef struct packed {
        logic [1:0]              operation;
        logic [FIELD_ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0]              status;
        logic                    accepted;
        logic                    load_miss;
        logic                    store_miss;
        logic                    eviction;
        logic                    writeback_valid;
        logic [FIELD_ADDR_W-1:0] writeback_addr;
        logic                    fetch_valid;
        logic [FIELD_ADDR_W-1:0] fetch_addr;
    } resp_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_LOOKUP,
        FSM_CLEAR
    } fsm_t;

endpackage

### rtl/nlc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module nlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/nonblocking_lru_cache_with_mshr.sv
// Top level: cache tag controller with LRU, lock bits and miss table.
//
//  channel | direction | handshake           | word
//  req     | in        | start & !busy       | req_t (operation, address)
//  resp    | out       | done strobe, 1 cyc  | resp_t (status, flags, addrs)
//
// For an item the set row is first read from the tag RAM (registered read),
// then the decision is made and the row written back; busy is high while
// deciding. After reset a clearing pass writes every set row once, and busy
// stays high meanwhile. Results are registered, come out in the cycle after
// the decision and cannot be stalled. Operation 3 produces no result.
module nonblocking_lru_cache_with_mshr #(
    parameter int NUM_SETS        = 256,
    parameter int WAYS            = 8,
    parameter int LINE_BYTES      = 64,
    parameter int PENDING_ENTRIES = 16,
    parameter int ADDR_BITS       = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  nlc_pkg::req_t req,
    output logic          done,
    output nlc_pkg::resp_t resp
);

    localparam int AW      = nlc_pkg::FIELD_ADDR_W;
    localparam int OFF     = $clog2(LINE_BYTES);
    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_B   = $clog2(NUM_SETS);
    localparam int TAG_OFF = OFF + SET_B;
    localparam int TAG_W   = (AW - TAG_OFF > 0) ? AW - TAG_OFF : 1;
    localparam int LINE_W  = AW - OFF;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int PE_W    = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int ROW_W   = WAYS * (3 + TAG_W + WAY_W);
    localparam int RAM_D   = (NUM_SETS > 1) ? NUM_SETS : 2;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic             locked;
        logic [TAG_W-1:0] tag;
    } way_t;

    typedef struct packed {
        way_t [WAYS-1:0]             ways;
        logic [WAYS-1:0][WAY_W-1:0]  order;
    } row_t;

    // address in effect is masked to ADDR_BITS
    function automatic logic [AW-1:0] mask_addr(input logic [AW-1:0] a);
        logic [AW-1:0] m;
        m = '1;
        if (ADDR_BITS < AW)
        begin
            m = (AW'(1) << ADDR_BITS) - AW'(1);
        end
        return a & m;
    endfunction

    nlc_pkg::fsm_t state_reg, state_next;
    logic [SET_W-1:0] clr_reg, clr_next;
    nlc_pkg::req_t    hold_reg;
    logic             done_reg, done_next;
    nlc_pkg::resp_t   resp_reg, resp_next;

    logic [PENDING_ENTRIES-1:0]             pv_reg, pv_next;
    logic [PENDING_ENTRIES-1:0][LINE_W-1:0] pl_reg, pl_next;
    logic [PENDING_ENTRIES-1:0][WAY_W-1:0]  pw_reg, pw_next;

    logic             ram_we;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    row_t             ram_wdata, ram_rdata;

    logic accept;
    assign accept = start && !busy;

    nlc_ram #(.WIDTH(ROW_W), .DEPTH(RAM_D)) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decoded fields of the held request
    logic [AW-1:0]     h_addr;
    logic [SET_W-1:0]  h_set;
    logic [TAG_W-1:0]  h_tag;
    logic [LINE_W-1:0] h_line;
    logic [AW-1:0]     acc_addr;
    assign acc_addr = mask_addr(req.address);
    assign h_addr = mask_addr(hold_reg.address);
    assign h_set  = (NUM_SETS > 1) ? SET_W'(h_addr >> OFF) : '0;
    assign h_tag  = (AW - TAG_OFF > 0) ? TAG_W'(h_addr >> TAG_OFF) : '0;
    assign h_line = LINE_W'(h_addr >> OFF);

    // read address: set of the incoming request
    always_comb
    begin
        ram_raddr = (NUM_SETS > 1) ? SET_W'(acc_addr >> OFF) : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            nlc_pkg::FSM_CLEAR:
            begin
                clr_next = clr_reg + SET_W'(1);
                if (32'(clr_reg) == NUM_SETS - 1)
                begin
                    state_next = nlc_pkg::FSM_IDLE;
                end
            end
            nlc_pkg::FSM_IDLE:
            begin
                if (accept && req.operation != nlc_pkg::OP_NONE)
                begin
                    state_next = nlc_pkg::FSM_LOOKUP;
                end
            end
            nlc_pkg::FSM_LOOKUP:
            begin
                state_next = nlc_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = nlc_pkg::FSM_IDLE;
            end
        endcase
    end

    // decision logic
    always_comb
    begin
        row_t              row;
        row_t              clr_row;
        logic              pend_f, free_ef, hit_f, free_wf, vic_f;
        logic [PE_W-1:0]   pend_i, free_e;
        logic [WAY_W-1:0]  hit_w, free_w, vic_w, pw, tgt;
        logic              touch;
        logic [WAYS-1:0][WAY_W-1:0] ord;
        logic              seen;
        logic [AW-1:0]     wb;

        row       = ram_rdata;
        pv_next   = pv_reg;
        pl_next   = pl_reg;
        pw_next   = pw_reg;
        resp_next = '0;
        done_next = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = h_set;
        pend_f = 1'b0; pend_i = '0; free_ef = 1'b0; free_e = '0;
        hit_f = 1'b0; hit_w = '0; free_wf = 1'b0; free_w = '0;
        vic_f = 1'b0; vic_w = '0; touch = 1'b0; tgt = '0;
        pw = '0; seen = 1'b0; wb = '0;

        for (int c = 0; c < WAYS; c++)
        begin
            clr_row.ways[c]  = '0;
            clr_row.order[c] = WAY_W'(c);
        end

        // miss table scan
        for (int e = 0; e < PENDING_ENTRIES; e++)
        begin
            if (pv_reg[e])
            begin
                if (!pend_f && pl_reg[e] == h_line)
                begin
                    pend_f = 1'b1;
                    pend_i = PE_W'(e);
                end
            end
            else if (!free_ef)
            begin
                free_ef = 1'b1;
                free_e  = PE_W'(e);
            end
        end
        pw = pw_reg[pend_i];

        // way scans
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_f && row.ways[w].valid && row.ways[w].tag == h_tag)
            begin
                hit_f = 1'b1;
                hit_w = WAY_W'(w);
            end
            if (!free_wf && !row.ways[w].valid)
            begin
                free_wf = 1'b1;
                free_w  = WAY_W'(w);
            end
        end
        for (int p = 0; p < WAYS; p++)
        begin
            if (!vic_f && row.ways[row.order[p]].valid && !row.ways[row.order[p]].locked)
            begin
                vic_f = 1'b1;
                vic_w = row.order[p];
            end
        end

        if (state_reg == nlc_pkg::FSM_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            row       = clr_row;
        end
        else if (state_reg == nlc_pkg::FSM_LOOKUP)
        begin
            done_next          = 1'b1;
            resp_next.accepted = 1'b1;
            if (hold_reg.operation == nlc_pkg::OP_FILL)
            begin
                if (pend_f)
                begin
                    row.ways[pw].locked = 1'b0;
                    pv_next[pend_i]     = 1'b0;
                    ram_we              = 1'b1;
                    resp_next.status    = nlc_pkg::ST_FILL_MATCH;
                end
                else
                begin
                    resp_next.status = nlc_pkg::ST_FILL_NONE;
                end
            end
            else if (hit_f && !row.ways[hit_w].locked)
            begin
                if (hold_reg.operation == nlc_pkg::OP_WRITE)
                begin
                    row.ways[hit_w].dirty = 1'b1;
                end
                touch            = 1'b1;
                tgt              = hit_w;
                ram_we           = 1'b1;
                resp_next.status = nlc_pkg::ST_HIT;
            end
            else
            begin
                resp_next.store_miss = (hold_reg.operation == nlc_pkg::OP_WRITE);
                resp_next.load_miss  = (hold_reg.operation != nlc_pkg::OP_WRITE);
                if (pend_f)
                begin
                    if (hold_reg.operation == nlc_pkg::OP_WRITE)
                    begin
                        row.ways[pw].dirty = 1'b1;
                        ram_we             = 1'b1;
                    end
                    resp_next.status = nlc_pkg::ST_PEND_HIT;
                end
                else if (!free_ef)
                begin
                    resp_next.status   = nlc_pkg::ST_STALL_TABLE;
                    resp_next.accepted = 1'b0;
                end
                else if (!free_wf && !vic_f)
                begin
                    resp_next.status   = nlc_pkg::ST_STALL_SET;
                    resp_next.accepted = 1'b0;
                end
                else
                begin
                    tgt   = free_wf ? free_w : vic_w;
                    if (!free_wf)
                    begin
                        resp_next.eviction = 1'b1;
                        if (row.ways[vic_w].dirty)
                        begin
                            wb = (AW'(row.ways[vic_w].tag) << TAG_OFF)
                                | (AW'(h_set) << OFF);
                            if (NUM_SETS == 1)
                            begin
                                wb = AW'(row.ways[vic_w].tag) << TAG_OFF;
                            end
                            resp_next.writeback_valid = 1'b1;
                            resp_next.writeback_addr  = wb;
                        end
                    end
                    row.ways[tgt].valid  = 1'b1;
                    row.ways[tgt].tag    = h_tag;
                    row.ways[tgt].dirty  = (hold_reg.operation == nlc_pkg::OP_WRITE);
                    row.ways[tgt].locked = 1'b1;
                    touch                = 1'b1;
                    ram_we               = 1'b1;
                    pv_next[free_e]      = 1'b1;
                    pl_next[free_e]      = h_line;
                    pw_next[free_e]      = tgt;
                    resp_next.status     = nlc_pkg::ST_MISS_ALLOC;
                    resp_next.fetch_valid = 1'b1;
                    resp_next.fetch_addr  = (AW'(h_line) << OFF);
                end
            end
        end

        // move the touched way to most recent
        ord = row.order;
        if (touch)
        begin
            for (int q = 0; q < WAYS - 1; q++)
            begin
                if (ord[q] == tgt)
                begin
                    seen = 1'b1;
                end
                row.order[q] = seen ? ord[q+1] : ord[q];
            end
            row.order[WAYS-1] = tgt;
        end
        ram_wdata = row;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nlc_pkg::FSM_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            pv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            pv_reg    <= pv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pl_reg   <= pl_next;
        pw_reg   <= pw_next;
        resp_reg <= resp_next;
        if (accept)
        begin
            hold_reg <= req;
        end
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != nlc_pkg::FSM_IDLE);
        done = done_reg;
        resp = resp_reg;
    end

    // terms for the checks below
    logic in_lookup, refused, stall_code, fetch_out, alloc_code, wb_out;
    assign in_lookup  = (state_reg == nlc_pkg::FSM_LOOKUP);
    assign refused    = done && !resp.accepted;
    assign stall_code = resp.status inside {nlc_pkg::ST_STALL_TABLE, nlc_pkg::ST_STALL_SET};
    assign fetch_out  = done && resp.fetch_valid;
    assign alloc_code = (resp.status == nlc_pkg::ST_MISS_ALLOC);
    assign wb_out     = done && resp.writeback_valid;

    `include "nonblocking_lru_cache_with_mshr_assert.svh"
    `NLC_ASSERT_NXT(a_lookup_done, clk, rst_n, in_lookup, done, "lookup without result")
    `NLC_ASSERT_IMP(a_stall_flag, clk, rst_n, refused, stall_code, "refused without stall code")
    `NLC_ASSERT_IMP(a_fetch_alloc, clk, rst_n, fetch_out, alloc_code, "fetch without allocation")
    `NLC_ASSERT_IMP(a_wb_evict, clk, rst_n, wb_out, resp.eviction, "writeback without eviction")

endmodule
